// File: design/pmq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the pruning message queue.
// Used by pmq_ram and pruning_message_queue_core; depends on nothing.
package pmq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KIND_W       = 5;

    // Request codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Message kinds
    localparam logic [KIND_W-1:0] K_MODE        = 5'd0;
    localparam logic [KIND_W-1:0] K_TRACK       = 5'd1;
    localparam logic [KIND_W-1:0] K_DRAIN       = 5'd2;
    localparam logic [KIND_W-1:0] K_DELAY       = 5'd3;
    localparam logic [KIND_W-1:0] K_ENCSTREAM   = 5'd4;
    localparam logic [KIND_W-1:0] K_AUDENC      = 5'd5;
    localparam logic [KIND_W-1:0] K_METATEXT    = 5'd6;
    localparam logic [KIND_W-1:0] K_INTERRUPTED = 5'd7;
    localparam logic [KIND_W-1:0] K_HALT        = 5'd8;
    localparam logic [KIND_W-1:0] K_FLUSH       = 5'd9;
    localparam logic [KIND_W-1:0] K_WAIT        = 5'd10;
    localparam logic [KIND_W-1:0] K_DECSTREAM   = 5'd11;
    localparam logic [KIND_W-1:0] K_BITRATE     = 5'd12;
    localparam logic [KIND_W-1:0] K_PCM         = 5'd13;
    localparam logic [KIND_W-1:0] K_DSD         = 5'd14;
    localparam logic [KIND_W-1:0] K_SILENCE     = 5'd15;
    localparam logic [KIND_W-1:0] K_PLAYABLE    = 5'd16;
    localparam logic [KIND_W-1:0] K_QUIT        = 5'd17;
    localparam logic [KIND_W-1:0] K_LAST        = 5'd31;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [15:0]       handle;
        logic [31:0]       jif;
        logic              ss;
        logic              mk;
    } entry_t;

    typedef struct packed {
        entry_t ent;
        logic   alive;
    } work_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEQ,
        ST_ENQ,
        ST_A_RD,
        ST_A_PROC,
        ST_A_ENT,
        ST_S_RD,
        ST_S_PROC,
        ST_D_RD,
        ST_D_PROC,
        ST_C_RD,
        ST_C_PROC
    } state_t;

endpackage

// File: design/pruning_message_queue_core.sv
`timescale 1ns / 1ps
// Top level of the pruning message queue: request FSM, pruning passes, result register.
// Depends on pmq_pkg and pmq_ram (entry store and pruning work store).

// One request item is handled at a time. A dequeue or an enqueue into a queue that is not
// full passes through the accept state, in which a dequeue reads the entry store, and a
// state that waits until the result register is free, then computes the enqueue slot,
// updates the store and loads the result register. An enqueue into a full queue runs four
// passes over the store, and each step waits on a registered memory read: a collapsing
// pass into the work store, a stage pass, a duplicate pass, and a compaction pass back
// into the entry store, after which the enqueue is tried as for a queue that is not full.
// The result register lets a new item be accepted while the last result is still stalled.
module pruning_message_queue_core
    import pmq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        func,
    input  logic [4:0]  msg_kind,
    input  logic [15:0] msg_handle,
    input  logic [31:0] duration_jiffies,
    input  logic        starts_stream,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        out_valid,
    output logic [4:0]  out_kind,
    output logic [15:0] out_handle,
    output logic [31:0] out_jiffies,
    output logic        out_starts_stream,
    output logic        out_is_marker,
    output logic [6:0]  queue_count,
    output logic [6:0]  pruned_count,
    output logic        enqueue_refused
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 1;
    localparam int EW = $bits(entry_t);
    localparam int WW = $bits(work_t);

    state_t state_reg, state_next;

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] size_reg, size_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] m_reg, m_next;
    logic [CW-1:0] keep_reg, keep_next;
    logic [CW-1:0] markers_reg, markers_next;
    logic [31:0]   acc_reg, acc_next;
    logic [CW-1:0] cm_reg, cm_next;
    logic [CW-1:0] ct_reg, ct_next;
    logic [CW-1:0] cd_reg, cd_next;
    logic [CW-1:0] cx_reg, cx_next;
    logic [CW-1:0] ch_reg, ch_next;
    logic [CW-1:0] cs_reg, cs_next;
    logic [PW-1:0] prn_reg, prn_next;

    // Latched request
    logic        func_reg;
    entry_t      req_ent_reg;

    // Result register
    logic        rsp_valid_reg, rsp_valid_next;
    logic        ov_reg, ov_next;
    entry_t      oent_reg, oent_next;
    logic [6:0]  qcnt_reg, qcnt_next;
    logic [6:0]  oprn_reg, oprn_next;
    logic        refused_reg, refused_next;

    // Memory ports
    logic          st_we, st_re, wk_we, wk_re;
    logic [IW-1:0] st_waddr, st_raddr, wk_waddr, wk_raddr;
    logic [EW-1:0] st_wdata, st_rdata;
    logic [WW-1:0] wk_wdata, wk_rdata;

    logic req_acc;
    logic out_free;

    // Add an offset to a slot index modulo the capacity
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] b, input logic [CW-1:0] o);
        logic [CW:0] s;
        s = {{(CW + 1 - IW){1'b0}}, b} + {1'b0, o};
        if (s >= (CW + 1)'(CAPACITY))
        begin
            s = s - (CW + 1)'(CAPACITY);
        end
        return s[IW-1:0];
    endfunction

    // Decrement that stops at zero
    function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] c);
        return (c != '0) ? c - CW'(1) : c;
    endfunction

    // Reduce a count to the 7-bit result field
    function automatic logic [6:0] to7(input logic [PW-1:0] v);
        logic [PW+6:0] x;
        x = {7'd0, v};
        return x[6:0];
    endfunction

    pmq_ram #(.W(EW), .DEPTH(CAPACITY)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    pmq_ram #(.W(WW), .DEPTH(CAPACITY)) u_work (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wdata),
        .re    (wk_re),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

    assign req_acc  = req_valid && (state_reg == ST_IDLE);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Next state, memory control and result
    always_comb
    begin
        entry_t      e;
        entry_t      mkr;
        work_t       w;
        logic [32:0] sum;
        logic [31:0] acc_new;
        logic        last;
        logic        alv;

        state_next     = state_reg;
        head_next      = head_reg;
        size_next      = size_reg;
        i_next         = i_reg;
        m_next         = m_reg;
        keep_next      = keep_reg;
        markers_next   = markers_reg;
        acc_next       = acc_reg;
        cm_next        = cm_reg;
        ct_next        = ct_reg;
        cd_next        = cd_reg;
        cx_next        = cx_reg;
        ch_next        = ch_reg;
        cs_next        = cs_reg;
        prn_next       = prn_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ov_next        = ov_reg;
        oent_next      = oent_reg;
        qcnt_next      = qcnt_reg;
        oprn_next      = oprn_reg;
        refused_next   = refused_reg;

        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        st_re    = 1'b0;
        st_raddr = head_reg;
        wk_we    = 1'b0;
        wk_waddr = m_reg[IW-1:0];
        wk_wdata = '0;
        wk_re    = 1'b0;
        wk_raddr = i_reg[IW-1:0];

        e        = entry_t'(st_rdata);
        w        = work_t'(wk_rdata);
        mkr.kind   = K_INTERRUPTED;
        mkr.handle = '0;
        mkr.jif    = acc_reg;
        mkr.ss     = 1'b0;
        mkr.mk     = 1'b1;
        sum      = {1'b0, acc_reg} + {1'b0, e.jif};
        acc_new  = sum[32] ? '1 : sum[31:0];
        last     = (i_reg == CW'(CAPACITY - 1));
        alv      = w.alive;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    prn_next = '0;
                    if (func == FUNC_DEQ)
                    begin
                        st_re      = 1'b1;
                        state_next = ST_DEQ;
                    end
                    else if (size_reg == CW'(CAPACITY))
                    begin
                        i_next       = '0;
                        m_next       = '0;
                        markers_next = '0;
                        acc_next     = '0;
                        cm_next      = '0;
                        ct_next      = '0;
                        cd_next      = '0;
                        cx_next      = '0;
                        ch_next      = '0;
                        cs_next      = '0;
                        state_next   = ST_A_RD;
                    end
                    else
                    begin
                        state_next = ST_ENQ;
                    end
                end
            end

            ST_DEQ:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    refused_next   = 1'b0;
                    oprn_next      = '0;
                    if (size_reg != '0)
                    begin
                        ov_next   = 1'b1;
                        oent_next = e;
                        head_next = wrap_add(head_reg, CW'(1));
                        size_next = size_reg - CW'(1);
                    end
                    else
                    begin
                        ov_next   = 1'b0;
                        oent_next = '0;
                    end
                    qcnt_next  = to7({1'b0, size_next});
                    state_next = ST_IDLE;
                end
            end

            ST_ENQ:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    ov_next        = 1'b0;
                    oent_next      = '0;
                    oprn_next      = to7(prn_reg);
                    if (size_reg == CW'(CAPACITY))
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        refused_next = 1'b0;
                        st_we        = 1'b1;
                        st_waddr     = wrap_add(head_reg, size_reg);
                        st_wdata     = req_ent_reg;
                        size_next    = size_reg + CW'(1);
                    end
                    qcnt_next  = to7({1'b0, size_next});
                    state_next = ST_IDLE;
                end
            end

            // Collapse audio runs while copying into the work store
            ST_A_RD:
            begin
                st_re      = 1'b1;
                st_raddr   = wrap_add(head_reg, i_reg);
                state_next = ST_A_PROC;
            end

            ST_A_PROC:
            begin
                if (e.kind == K_PCM || e.kind == K_DSD || e.kind == K_SILENCE)
                begin
                    acc_next = acc_new;
                    if (last && acc_new != '0)
                    begin
                        mkr.jif      = acc_new;
                        wk_we        = 1'b1;
                        wk_wdata     = {mkr, 1'b1};
                        m_next       = m_reg + CW'(1);
                        markers_next = markers_reg + CW'(1);
                    end
                    i_next     = i_reg + CW'(1);
                    state_next = last ? ST_S_RD : ST_A_RD;
                    if (last)
                    begin
                        i_next = '0;
                    end
                end
                else if (acc_reg != '0)
                begin
                    wk_we        = 1'b1;
                    wk_wdata     = {mkr, 1'b1};
                    m_next       = m_reg + CW'(1);
                    markers_next = markers_reg + CW'(1);
                    acc_next     = '0;
                    state_next   = ST_A_ENT;
                end
                else
                begin
                    state_next = ST_A_ENT;
                end
            end

            ST_A_ENT:
            begin
                wk_we    = 1'b1;
                wk_wdata = {e, 1'b1};
                m_next   = m_reg + CW'(1);
                case (e.kind)
                    K_MODE:      cm_next = cm_reg + CW'(1);
                    K_TRACK:     ct_next = e.ss ? ct_reg + CW'(1) : ct_reg;
                    K_DELAY:     cd_next = cd_reg + CW'(1);
                    K_METATEXT:  cx_next = cx_reg + CW'(1);
                    K_HALT:      ch_next = ch_reg + CW'(1);
                    K_DECSTREAM: cs_next = cs_reg + CW'(1);
                    default:     ;
                endcase
                i_next     = last ? '0 : i_reg + CW'(1);
                state_next = last ? ST_S_RD : ST_A_RD;
            end

            // Mode, track and stream stages in one forward walk
            ST_S_RD:
            begin
                if (i_reg == m_reg || (cm_reg == '0 && ct_reg == '0 && cs_reg == '0))
                begin
                    i_next     = '0;
                    state_next = ST_D_RD;
                end
                else
                begin
                    wk_re      = 1'b1;
                    state_next = ST_S_PROC;
                end
            end

            ST_S_PROC:
            begin
                if (cm_reg != '0)
                begin
                    if (w.ent.kind == K_MODE)
                    begin
                        cm_next = cm_reg - CW'(1);
                    end
                    else if (!(w.ent.kind inside {K_INTERRUPTED, [K_QUIT:K_LAST]}))
                    begin
                        alv = 1'b0;
                        if (w.ent.kind == K_TRACK && w.ent.ss)
                            ct_next = dec_sat(ct_reg);
                        else if (w.ent.kind == K_DELAY)
                            cd_next = dec_sat(cd_reg);
                        else if (w.ent.kind == K_METATEXT)
                            cx_next = dec_sat(cx_reg);
                        else if (w.ent.kind == K_HALT)
                            ch_next = dec_sat(ch_reg);
                        else if (w.ent.kind == K_DECSTREAM)
                            cs_next = dec_sat(cs_reg);
                    end
                end
                else if (ct_reg != '0)
                begin
                    if (w.ent.kind == K_TRACK)
                    begin
                        if (w.ent.ss)
                        begin
                            ct_next = ct_reg - CW'(1);
                            alv     = (ct_reg == CW'(1));
                        end
                    end
                    else if (!(w.ent.kind inside {K_MODE, K_DELAY, K_INTERRUPTED,
                                                  [K_QUIT:K_LAST]}))
                    begin
                        alv = 1'b0;
                        if (w.ent.kind == K_METATEXT)
                            cx_next = dec_sat(cx_reg);
                        else if (w.ent.kind == K_HALT)
                            ch_next = dec_sat(ch_reg);
                        else if (w.ent.kind == K_DECSTREAM)
                            cs_next = dec_sat(cs_reg);
                    end
                end
                else
                begin
                    if (w.ent.kind == K_DECSTREAM)
                    begin
                        cs_next = cs_reg - CW'(1);
                        alv     = (cs_reg == CW'(1));
                    end
                    else if (!(w.ent.kind inside {K_MODE, K_TRACK, K_DELAY, K_ENCSTREAM,
                                                  K_INTERRUPTED, [K_QUIT:K_LAST]}))
                    begin
                        alv = 1'b0;
                        if (w.ent.kind == K_METATEXT)
                            cx_next = dec_sat(cx_reg);
                        else if (w.ent.kind == K_HALT)
                            ch_next = dec_sat(ch_reg);
                    end
                end
                wk_we      = 1'b1;
                wk_waddr   = i_reg[IW-1:0];
                wk_wdata   = {w.ent, alv};
                i_next     = i_reg + CW'(1);
                state_next = ST_S_RD;
            end

            // Keep only the last delay, metatext and halt
            ST_D_RD:
            begin
                if (i_reg == m_reg ||
                    (cd_reg <= CW'(1) && cx_reg <= CW'(1) && ch_reg <= CW'(1)))
                begin
                    i_next     = '0;
                    keep_next  = '0;
                    state_next = ST_C_RD;
                end
                else
                begin
                    wk_re      = 1'b1;
                    state_next = ST_D_PROC;
                end
            end

            ST_D_PROC:
            begin
                if (w.alive)
                begin
                    if (w.ent.kind == K_DELAY && cd_reg > CW'(1))
                    begin
                        cd_next = cd_reg - CW'(1);
                        alv     = 1'b0;
                    end
                    else if (w.ent.kind == K_METATEXT && cx_reg > CW'(1))
                    begin
                        cx_next = cx_reg - CW'(1);
                        alv     = 1'b0;
                    end
                    else if (w.ent.kind == K_HALT && ch_reg > CW'(1))
                    begin
                        ch_next = ch_reg - CW'(1);
                        alv     = 1'b0;
                    end
                end
                wk_we      = 1'b1;
                wk_waddr   = i_reg[IW-1:0];
                wk_wdata   = {w.ent, alv};
                i_next     = i_reg + CW'(1);
                state_next = ST_D_RD;
            end

            // Compact surviving entries back into the store from slot zero
            ST_C_RD:
            begin
                if (i_reg == m_reg)
                begin
                    prn_next   = {1'b0, size_reg} + {1'b0, markers_reg} - {1'b0, keep_reg};
                    head_next  = '0;
                    size_next  = keep_reg;
                    state_next = ST_ENQ;
                end
                else
                begin
                    wk_re      = 1'b1;
                    state_next = ST_C_PROC;
                end
            end

            ST_C_PROC:
            begin
                if (w.alive)
                begin
                    st_we     = 1'b1;
                    st_waddr  = keep_reg[IW-1:0];
                    st_wdata  = w.ent;
                    keep_next = keep_reg + CW'(1);
                end
                i_next     = i_reg + CW'(1);
                state_next = ST_C_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            size_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            i_reg         <= '0;
            m_reg         <= '0;
            keep_reg      <= '0;
            markers_reg   <= '0;
            acc_reg       <= '0;
            cm_reg        <= '0;
            ct_reg        <= '0;
            cd_reg        <= '0;
            cx_reg        <= '0;
            ch_reg        <= '0;
            cs_reg        <= '0;
            prn_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            size_reg      <= size_next;
            rsp_valid_reg <= rsp_valid_next;
            i_reg         <= i_next;
            m_reg         <= m_next;
            keep_reg      <= keep_next;
            markers_reg   <= markers_next;
            acc_reg       <= acc_next;
            cm_reg        <= cm_next;
            ct_reg        <= ct_next;
            cd_reg        <= cd_next;
            cx_reg        <= cx_next;
            ch_reg        <= ch_next;
            cs_reg        <= cs_next;
            prn_reg       <= prn_next;
        end
    end

    // Payload registers: latched request and result fields
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            func_reg           <= func;
            req_ent_reg.kind   <= msg_kind;
            req_ent_reg.handle <= msg_handle;
            req_ent_reg.jif    <= duration_jiffies;
            req_ent_reg.ss     <= starts_stream;
            req_ent_reg.mk     <= 1'b0;
        end
        ov_reg      <= ov_next;
        oent_reg    <= oent_next;
        qcnt_reg    <= qcnt_next;
        oprn_reg    <= oprn_next;
        refused_reg <= refused_next;
    end

    assign req_stall         = (state_reg != ST_IDLE);
    assign rsp_valid         = rsp_valid_reg;
    assign out_valid         = ov_reg;
    assign out_kind          = oent_reg.kind;
    assign out_handle        = oent_reg.handle;
    assign out_jiffies       = oent_reg.jif;
    assign out_starts_stream = oent_reg.ss;
    assign out_is_marker     = oent_reg.mk;
    assign queue_count       = qcnt_reg;
    assign pruned_count      = oprn_reg;
    assign enqueue_refused   = refused_reg;

    // Queue never holds more than its capacity
    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= CW'(CAPACITY))
        else $error("queue size beyond capacity");

    // Work entries never outnumber the scanned store entries
    a_work_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_PROC || state_reg == ST_A_ENT) |-> m_reg <= i_reg + CW'(1))
        else $error("work store overran scan position");

    // A dequeue result never reports pruning or refusal
    a_deq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEQ && state_next == ST_IDLE) |=> (!refused_reg && oprn_reg == '0))
        else $error("dequeue result carries enqueue status");

    // A dequeue request takes the dequeue path
    a_deq_path: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && func == FUNC_DEQ) |=> (state_reg == ST_DEQ && func_reg == FUNC_DEQ))
        else $error("dequeue request lost its path");

endmodule

// File: design/pmq_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// Uses pmq_pkg for the default depth CAPACITY_DEF; no submodules.
module pmq_ram
    import pmq_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
